/* src/pfd_pkg.sv */
package pfd_pkg;

    // Frame delimiters.
    localparam logic [7:0] HDR_FIRST  = 8'h0D;
    localparam logic [7:0] HDR_SECOND = 8'h0A;
    localparam logic [7:0] TRL_FIRST  = 8'h0A;
    localparam logic [7:0] TRL_SECOND = 8'h0D;

    // Frame geometry.
    localparam int PAYLOAD_LEN = 24;
    localparam int WORD_COUNT  = 6;
    localparam int IDX_W       = $clog2(PAYLOAD_LEN);

    // Frame phase codes.
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR2    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd2;
    localparam logic [PHASE_W-1:0] PH_TRL1    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TRL2    = 3'd4;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [31:0] word_t;

endpackage

/* src/pose_frame_deframer.sv */
// Pose frame deframer. Each input transaction carries one received serial
// byte. The block hunts for the header 0x0D 0x0A (extra 0x0D bytes keep it
// waiting for the 0x0A), stores the next 24 bytes whatever their values, and
// then expects the trailer 0x0A 0x0D. A good trailer produces one output
// transaction of six 32-bit words, each packed little-endian from four
// payload bytes in order: z angle, x angle, y angle, x position, y position
// and yaw rate. The words are float bit patterns passed through unchanged.
// A mismatching byte returns the block to the hunt and is not itself taken as
// a header start. Rate: one byte per clock cycle. A byte is registered on
// acceptance and then processed from that register by the phase machine; the
// only thing that can hold off input is a finished frame that sits in the
// output register while the downstream side does not take it. The frame is
// loaded into the output register when the phase machine takes the final
// trailer byte from the input register.
module pose_frame_deframer
    import pfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] z_angle_bits,
    output logic [31:0] x_angle_bits,
    output logic [31:0] y_angle_bits,
    output logic [31:0] position_x_bits,
    output logic [31:0] position_y_bits,
    output logic [31:0] yaw_rate_bits
);

    // Input register: holds the accepted byte while the phase machine processes it.
    logic        stage_valid_reg;
    logic [7:0]  stage_byte_reg;

    // Frame state.
    logic [PHASE_W-1:0] phase_reg, phase_next;
    idx_t               index_reg, index_next;
    logic [7:0]         payload_store_reg [PAYLOAD_LEN];

    // Output register.
    logic  out_valid_reg;
    word_t out_word_reg [WORD_COUNT];
    word_t packed_word  [WORD_COUNT];

    logic emit;
    logic advance;
    logic store_en;

    // A good final trailer byte completes a frame.
    assign emit = (phase_reg == PH_TRL2) && (stage_byte_reg == TRL_SECOND);

    // The staged byte moves on unless it completes a frame while the output
    // register still holds one that has not been taken.
    assign advance  = stage_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    always_comb
    begin
        phase_next = phase_reg;
        index_next = index_reg;
        store_en   = 1'b0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                phase_next = (stage_byte_reg == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
            end
            PH_HDR2:
            begin
                if (stage_byte_reg == HDR_SECOND)
                begin
                    index_next = '0;
                    phase_next = PH_PAYLOAD;
                end
                else if (stage_byte_reg != HDR_FIRST)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_PAYLOAD:
            begin
                if (index_reg < idx_t'(PAYLOAD_LEN - 1))
                begin
                    store_en   = 1'b1;
                    index_next = index_reg + idx_t'(1);
                end
                else
                begin
                    // The last payload byte, or an index that is out of range,
                    // closes the payload.
                    store_en   = (index_reg == idx_t'(PAYLOAD_LEN - 1));
                    index_next = '0;
                    phase_next = PH_TRL1;
                end
            end
            PH_TRL1:
            begin
                phase_next = (stage_byte_reg == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
            end
            PH_TRL2:
            begin
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Little-endian packing of the payload into words.
    always_comb
    begin
        for (int k = 0; k < WORD_COUNT; k++)
        begin
            packed_word[k] = {payload_store_reg[4*k+3], payload_store_reg[4*k+2],
                              payload_store_reg[4*k+1], payload_store_reg[4*k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            phase_reg       <= PH_HUNT;
            index_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                index_reg <= index_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_byte_reg <= rx_byte;
        end
        if (advance && store_en)
        begin
            payload_store_reg[index_reg] <= stage_byte_reg;
        end
        if (advance && emit)
        begin
            for (int k = 0; k < WORD_COUNT; k++)
            begin
                out_word_reg[k] <= packed_word[k];
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign z_angle_bits    = out_word_reg[0];
    assign x_angle_bits    = out_word_reg[1];
    assign y_angle_bits    = out_word_reg[2];
    assign position_x_bits = out_word_reg[3];
    assign position_y_bits = out_word_reg[4];
    assign yaw_rate_bits   = out_word_reg[5];

    // A completed frame that is allowed to advance shows up on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> out_valid_reg)
        else $error("completed frame did not reach the output register");

    // A new output transaction only follows the final trailer phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(phase_reg) == PH_TRL2))
        else $error("output raised outside the final trailer phase");

    // The payload index is cleared whenever the block is outside the payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_PAYLOAD) |-> (index_reg == '0))
        else $error("payload index not cleared outside the payload phase");

    // The index never leaves the payload range.
    assert property (@(posedge clk) disable iff (!rst_n)
        index_reg < idx_t'(PAYLOAD_LEN))
        else $error("payload index out of range");

    // A held byte is not overwritten while its frame waits for the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=> $stable(stage_byte_reg))
        else $error("staged byte changed while stalled");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

// Testbench for the pose frame deframer. Serial bytes are pushed in over the
// input handshake while a scoreboard predicts, byte by byte, which frames the
// block must emit. Each output transaction is compared word by word with the
// oldest predicted frame. The stimulus is mostly well-formed frames with
// random payloads, mixed with broken frames and line noise.
module tb_top;
    import pfd_pkg::*;

    // One decoded frame: word 0 is the z angle, word 5 the yaw rate.
    typedef logic [WORD_COUNT-1:0][31:0] frame_t;

    typedef enum int
    {
        FR_GOOD,
        FR_BAD_HDR2,
        FR_BAD_TRL1,
        FR_BAD_TRL2
    } frame_flavor_e;

    typedef enum int
    {
        PL_ZERO,
        PL_ONES,
        PL_COUNT,
        PL_RANDOM
    } payload_mode_e;

    localparam int unsigned RANDOM_BYTES = 1300;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_REPORTS  = 10;

    // The scoreboard tracks the framing state on its own copy of the phase,
    // the fill position and the payload bytes. Every completed frame is
    // queued as the words that the block must later put out.
    class PoseFrameScoreboard;
        logic [PHASE_W-1:0] phase;
        int unsigned        fill;
        logic [7:0]         payload [PAYLOAD_LEN];
        frame_t             predicted_frames [$];
        int unsigned        failures;
        string              field_names [WORD_COUNT];

        function new();
            phase = PH_HUNT;
            fill = 0;
            failures = 0;
            field_names = '{"z_angle_bits", "x_angle_bits", "y_angle_bits",
                            "position_x_bits", "position_y_bits", "yaw_rate_bits"};
        endfunction

        function void absorb_byte(logic [7:0] b);
            frame_t f;
            int     k;
            unique case (phase)
                PH_HUNT:
                    phase = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
                PH_HDR2:
                begin
                    // Extra carriage returns keep the block waiting for the
                    // line feed; anything else drops back to the hunt.
                    if (b == HDR_SECOND)
                    begin
                        fill = 0;
                        phase = PH_PAYLOAD;
                    end
                    else if (b != HDR_FIRST)
                    begin
                        phase = PH_HUNT;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (fill < PAYLOAD_LEN)
                    begin
                        payload[fill] = b;
                        fill++;
                    end
                    if (fill >= PAYLOAD_LEN)
                    begin
                        fill = 0;
                        phase = PH_TRL1;
                    end
                end
                PH_TRL1:
                    phase = (b == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
                PH_TRL2:
                begin
                    if (b == TRL_SECOND)
                    begin
                        for (k = 0; k < WORD_COUNT; k++)
                        begin
                            f[k] = {payload[4*k+3], payload[4*k+2],
                                    payload[4*k+1], payload[4*k]};
                        end
                        predicted_frames.push_back(f);
                    end
                    phase = PH_HUNT;
                end
                default:
                    phase = PH_HUNT;
            endcase
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
            begin
                $display("%s", msg);
            end
        endfunction

        function void check_frame(frame_t got);
            frame_t want;
            int     k;
            if (predicted_frames.size() == 0)
            begin
                flag($sformatf("%0t: frame with no prediction, z_angle_bits %08h",
                               $time, got[0]));
                return;
            end
            want = predicted_frames.pop_front();
            for (k = 0; k < WORD_COUNT; k++)
            begin
                if (want[k] !== got[k])
                begin
                    flag($sformatf("%0t: %s expected %08h, got %08h",
                                   $time, field_names[k], want[k], got[k]));
                end
            end
        endfunction

        function int unsigned pending();
            return predicted_frames.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] z_angle_bits;
    logic [31:0] x_angle_bits;
    logic [31:0] y_angle_bits;
    logic [31:0] position_x_bits;
    logic [31:0] position_y_bits;
    logic [31:0] yaw_rate_bits;

    PoseFrameScoreboard sb = new();

    // Per-cycle idle chances of the two sides, changed between test phases.
    int unsigned send_idle_pct = 13;
    int unsigned recv_stall_pct = 46;
    int unsigned bytes_sent = 0;
    int unsigned cycles = 0;

    pose_frame_deframer dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .z_angle_bits    (z_angle_bits),
        .x_angle_bits    (x_angle_bits),
        .y_angle_bits    (y_angle_bits),
        .position_x_bits (position_x_bits),
        .position_y_bits (position_y_bits),
        .yaw_rate_bits   (yaw_rate_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("pose_frame_deframer regression: fail");
            $finish;
        end
    end

    // Picks delimiter values and the byte extremes often, so that payloads
    // and noise frequently look like headers or trailers.
    function automatic logic [7:0] biased_byte();
        case ($urandom_range(9))
            0: return HDR_FIRST;
            1: return HDR_SECOND;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] byte_other_than(logic [7:0] v);
        logic [7:0] b;
        do
            b = biased_byte();
        while (b == v);
        return b;
    endfunction

    function automatic logic [7:0] payload_byte(payload_mode_e mode, int pos);
        case (mode)
            PL_ZERO:  return 8'h00;
            PL_ONES:  return 8'hFF;
            PL_COUNT: return 8'(pos * 11 + 1);
            default:  return biased_byte();
        endcase
    endfunction

    // Offers one byte and holds it until the block takes it. Inputs change
    // only right after a rising edge; in_ready is read just after the edge,
    // before the block's registers update, so it is the value the block saw.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.absorb_byte(b);
        bytes_sent++;
    endtask

    task automatic send_payload(input payload_mode_e mode);
        int i;
        for (i = 0; i < PAYLOAD_LEN; i++)
        begin
            send_byte(payload_byte(mode, i));
        end
    endtask

    // One frame from header to trailer. The broken flavors spoil exactly one
    // delimiter byte; the rest of the frame is still sent, so that its bytes
    // hit the block while it hunts.
    task automatic send_frame(input frame_flavor_e flavor, input payload_mode_e mode,
                              input int unsigned extra_cr);
        logic [7:0] b;
        send_byte(HDR_FIRST);
        repeat (extra_cr) send_byte(HDR_FIRST);
        if (flavor == FR_BAD_HDR2)
        begin
            do
                b = biased_byte();
            while (b == HDR_SECOND || b == HDR_FIRST);
            send_byte(b);
        end
        else
        begin
            send_byte(HDR_SECOND);
        end
        send_payload(mode);
        send_byte((flavor == FR_BAD_TRL1) ? byte_other_than(TRL_FIRST) : TRL_FIRST);
        send_byte((flavor == FR_BAD_TRL2) ? byte_other_than(TRL_SECOND) : TRL_SECOND);
    endtask

    // Downstream side: checks each frame taken and stalls at random. Outputs
    // are read right after the edge, so they are the values at that edge.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_frame({yaw_rate_bits, position_y_bits, position_x_bits,
                                y_angle_bits, x_angle_bits, z_angle_bits});
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int unsigned random_start;
        int unsigned roll;
        int unsigned extra;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: all-zero and all-one payloads, a header with
        // repeated carriage returns, and a payload with distinct bytes so
        // that any byte-order slip in the words shows.
        send_frame(FR_GOOD, PL_ZERO, 0);
        send_frame(FR_GOOD, PL_ONES, 2);
        send_frame(FR_GOOD, PL_COUNT, 0);

        // Each kind of broken delimiter; the first two are each followed by a clean
        // frame so that recovery from the hunt is checked too.
        send_frame(FR_BAD_HDR2, PL_COUNT, 0);
        send_frame(FR_GOOD, PL_RANDOM, 0);
        send_frame(FR_BAD_TRL1, PL_RANDOM, 1);
        send_frame(FR_GOOD, PL_RANDOM, 0);
        send_frame(FR_BAD_TRL2, PL_RANDOM, 0);

        // A carriage return in place of the first trailer byte fails the
        // trailer and must not count as a header start, so the line feed and
        // payload that follow are only noise and no frame comes out.
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_payload(PL_ONES);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_payload(PL_COUNT);
        send_byte(TRL_FIRST);
        send_byte(TRL_SECOND);

        // A final byte of line feed instead of carriage return: no frame.
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_payload(PL_ZERO);
        send_byte(TRL_FIRST);
        send_byte(TRL_FIRST);
        send_frame(FR_GOOD, PL_ONES, 0);

        // Random part. Idling changes in thirds: light sender idling with a
        // slow receiver, then the reverse, then full rate on both sides.
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            if (bytes_sent - random_start >= 2 * RANDOM_BYTES / 3)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            else if (bytes_sent - random_start >= RANDOM_BYTES / 3)
            begin
                send_idle_pct = 46;
                recv_stall_pct = 13;
            end
            roll = $urandom_range(99);
            extra = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
            if (roll < 70)
            begin
                send_frame(FR_GOOD, PL_RANDOM, extra);
            end
            else if (roll < 90)
            begin
                send_frame(frame_flavor_e'($urandom_range(FR_BAD_HDR2, FR_BAD_TRL2)),
                           PL_RANDOM, extra);
            end
            else
            begin
                repeat ($urandom_range(1, 8)) send_byte(biased_byte());
            end
        end
        in_valid <= 1'b0;

        // Let every predicted frame drain, then wait out a further drain period for
        // any frame the block should not have produced.
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0)
        begin
            $display("pose_frame_deframer regression: pass");
        end
        else
        begin
            $display("pose_frame_deframer regression: fail");
        end
        $finish;
    end

endmodule
